// ----- sv/hsv_to_rgb_converter_assert.svh -----
// Assertion macros for the HSV to RGB converter.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HSVRGB_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_converter: check failed");

// next-cycle implication, checked outside reset
`define HSVRGB_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_converter: check failed");

`endif

// ----- sv/hsvrgb_pkg.sv -----
// Shared types and constants of the HSV to RGB converter.
// No dependencies.
package hsvrgb_pkg;

  localparam int unsigned NUM_STAGES = 6;

  localparam int unsigned HUE_W  = 15;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned REM_W  = 12;
  localparam int unsigned SEC_W  = 3;
  localparam int unsigned PROD_W = 20;   // s*rem and the scaled numerator terms
  localparam int unsigned NUM_W  = 28;   // v*(D - s*frac)
  localparam int unsigned PN_W   = 16;   // v*(255-s)

  localparam logic [HUE_W-1:0]  HUE_TURN   = 15'd23040;
  localparam logic [HUE_W-1:0]  HUE_SECTOR = 15'd3840;
  localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [PROD_W-1:0] SECTOR_DEN = 20'd979200;   // 255 * 3840

  // floor(x/255) for x < 2^16: (x * PRECIP) >> PSHIFT
  localparam int unsigned       PSHIFT   = 24;
  localparam longint unsigned   PRECIP_L = ((64'd1 << PSHIFT) + 64'd254) / 64'd255;
  localparam int unsigned       PRECIP_W = 17;
  localparam logic [PRECIP_W-1:0] PRECIP = PRECIP_L[PRECIP_W-1:0];

  // D = 3825 * 256; floor(n/D) = floor((n >> 8) / 3825), the latter by reciprocal
  localparam int unsigned       QPRE     = 8;
  localparam int unsigned       QSHIFT   = 32;
  localparam longint unsigned   QRECIP_L = ((64'd1 << QSHIFT) + 64'd3824) / 64'd3825;
  localparam int unsigned       QRECIP_W = 21;
  localparam logic [QRECIP_W-1:0] QRECIP = QRECIP_L[QRECIP_W-1:0];

  localparam logic [SEC_W-1:0] SEC_RED_YEL = 3'd0;
  localparam logic [SEC_W-1:0] SEC_YEL_GRN = 3'd1;
  localparam logic [SEC_W-1:0] SEC_GRN_CYN = 3'd2;
  localparam logic [SEC_W-1:0] SEC_CYN_BLU = 3'd3;
  localparam logic [SEC_W-1:0] SEC_BLU_MAG = 3'd4;
  localparam logic [SEC_W-1:0] SEC_MAG_RED = 3'd5;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctl_t;

  function automatic logic [SEC_W-1:0] hue_sector(input logic [HUE_W-1:0] h);
    logic [SEC_W-1:0] sec;
    sec = '0;
    for (int k = 1; k < 6; k++) begin
      if (h >= HUE_W'(k * 3840)) sec = SEC_W'(k);
    end
    return sec;
  endfunction

  function automatic logic [HUE_W-1:0] sector_base(input logic [SEC_W-1:0] sec);
    logic [HUE_W-1:0] base;
    case (sec)
      SEC_RED_YEL: base = 15'd0;
      SEC_YEL_GRN: base = 15'd3840;
      SEC_GRN_CYN: base = 15'd7680;
      SEC_CYN_BLU: base = 15'd11520;
      SEC_BLU_MAG: base = 15'd15360;
      SEC_MAG_RED: base = 15'd19200;
      default:     base = 15'd0;
    endcase
    return base;
  endfunction

endpackage

// ----- sv/hsvrgb_pipe_ctl.sv -----
// Valid bits and per-stage load enables of the converter pipeline.
// Depends on hsvrgb_pkg. Bubbles collapse; a stall holds each full stage with no empty stage after it.
module hsvrgb_pipe_ctl
  import hsvrgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_ready,
  output logic      in_ready,
  output pipe_ctl_t ctl
);

  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !valid_r[i] || adv[i+1];
    end
    valid_nxt = valid_r;
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (adv[i]) begin
        valid_nxt[i] = (i == 0) ? in_valid : valid_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = adv[0];
  assign ctl.load  = adv;
  assign ctl.valid = valid_r;

endmodule

// ----- sv/hsv_to_rgb_converter.sv -----
// HSV to RGB converter, top level: six-stage arithmetic pipeline.
// Depends on hsvrgb_pkg, hsvrgb_pipe_ctl and hsv_to_rgb_converter_assert.svh.
//
// Usage:
//   in_* carries one pixel request per handshake (hue in 1/64 degree,
//   saturation and value with 255 as full scale). out_* returns one
//   request with the 8-bit red, green and blue channels, in order.
//   Hue values of 23040 and above map to 0; zero saturation yields gray.
// Timing:
//   One pixel is accepted every clock unless a stall has filled every
//   stage; the rate is set by the six register stages
//   (wrap and sector split, three products, subtract, value products,
//   reciprocal divide, channel select), each taking a new pixel per cycle.
// Reset:
//   rst_n low clears every valid bit; no request is pending afterwards.
// Stall:
//   When out_tready is low the output holds; earlier stages keep filling
//   empty slots, and in_tready drops only once all six stages are full.
//   Nothing is lost or repeated.
module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // hue[14:0], saturation[22:15], brightness[30:23], 0
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  pipe_ctl_t ctl;

  hsvrgb_pipe_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_ready(out_tready),
    .in_ready (in_tready),
    .ctl      (ctl)
  );

  // stage 1: hue wrap, sector and remainder
  logic [HUE_W-1:0]  hue_in;
  logic [HUE_W-1:0]  hue_wrap;
  logic [SEC_W-1:0]  sec1_r,  sec1_nxt;
  logic [REM_W-1:0]  rem1_r,  rem1_nxt;
  logic [CHAN_W-1:0] s1_r, v1_r;
  logic [HUE_W-1:0]  rem_full;

  assign hue_in   = in_tdata[14:0];
  assign hue_wrap = (hue_in >= HUE_TURN) ? '0 : hue_in;
  assign sec1_nxt = hue_sector(hue_wrap);
  assign rem_full = hue_wrap - sector_base(sec1_nxt);
  assign rem1_nxt = rem_full[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      sec1_r <= sec1_nxt;
      rem1_r <= rem1_nxt;
      s1_r   <= in_tdata[22:15];
      v1_r   <= in_tdata[30:23];
    end
  end

  // stage 2: s*rem, s*(3840-rem), v*(255-s)
  logic [PROD_W-1:0] prq2_r, prq2_nxt;
  logic [PROD_W-1:0] prt2_r, prt2_nxt;
  logic [PN_W-1:0]   pn2_r,  pn2_nxt;
  logic [REM_W:0]    rem_c;
  logic [SEC_W-1:0]  sec2_r;
  logic [CHAN_W-1:0] s2_r, v2_r;

  assign rem_c    = HUE_SECTOR[REM_W:0] - {1'b0, rem1_r};
  assign prq2_nxt = PROD_W'(s1_r) * PROD_W'(rem1_r);
  assign prt2_nxt = PROD_W'(s1_r) * PROD_W'(rem_c);
  assign pn2_nxt  = PN_W'(v1_r) * PN_W'(FULL_SCALE - s1_r);

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      prq2_r <= prq2_nxt;
      prt2_r <= prt2_nxt;
      pn2_r  <= pn2_nxt;
      sec2_r <= sec1_r;
      s2_r   <= s1_r;
      v2_r   <= v1_r;
    end
  end

  // stage 3: D - products, p by reciprocal of 255
  logic [PROD_W-1:0]          aq3_r, aq3_nxt;
  logic [PROD_W-1:0]          at3_r, at3_nxt;
  logic [PN_W+PRECIP_W-1:0]   pprod;
  logic [CHAN_W-1:0]          p3_r, p3_nxt;
  logic [SEC_W-1:0]           sec3_r;
  logic [CHAN_W-1:0]          s3_r, v3_r;

  assign aq3_nxt = SECTOR_DEN - prq2_r;
  assign at3_nxt = SECTOR_DEN - prt2_r;
  assign pprod   = (PN_W+PRECIP_W)'(pn2_r) * (PN_W+PRECIP_W)'(PRECIP);
  assign p3_nxt  = pprod[PSHIFT +: CHAN_W];

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      aq3_r  <= aq3_nxt;
      at3_r  <= at3_nxt;
      p3_r   <= p3_nxt;
      sec3_r <= sec2_r;
      s3_r   <= s2_r;
      v3_r   <= v2_r;
    end
  end

  // stage 4: v * (D - s*frac)
  logic [NUM_W-1:0]  nq4_r, nq4_nxt;
  logic [NUM_W-1:0]  nt4_r, nt4_nxt;
  logic [CHAN_W-1:0] p4_r;
  logic [SEC_W-1:0]  sec4_r;
  logic [CHAN_W-1:0] s4_r, v4_r;

  assign nq4_nxt = NUM_W'(v3_r) * NUM_W'(aq3_r);
  assign nt4_nxt = NUM_W'(v3_r) * NUM_W'(at3_r);

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      nq4_r  <= nq4_nxt;
      nt4_r  <= nt4_nxt;
      p4_r   <= p3_r;
      sec4_r <= sec3_r;
      s4_r   <= s3_r;
      v4_r   <= v3_r;
    end
  end

  // stage 5: divide by D
  localparam int unsigned XW = NUM_W - QPRE;
  logic [XW+QRECIP_W-1:0] qprod, tprod;
  logic [CHAN_W-1:0]      q5_r, q5_nxt;
  logic [CHAN_W-1:0]      t5_r, t5_nxt;
  logic [CHAN_W-1:0]      p5_r;
  logic [SEC_W-1:0]       sec5_r;
  logic [CHAN_W-1:0]      s5_r, v5_r;

  assign qprod  = (XW+QRECIP_W)'(nq4_r[NUM_W-1:QPRE]) * (XW+QRECIP_W)'(QRECIP);
  assign tprod  = (XW+QRECIP_W)'(nt4_r[NUM_W-1:QPRE]) * (XW+QRECIP_W)'(QRECIP);
  assign q5_nxt = qprod[QSHIFT +: CHAN_W];
  assign t5_nxt = tprod[QSHIFT +: CHAN_W];

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      q5_r   <= q5_nxt;
      t5_r   <= t5_nxt;
      p5_r   <= p4_r;
      sec5_r <= sec4_r;
      s5_r   <= s4_r;
      v5_r   <= v4_r;
    end
  end

  // stage 6: channel select, output register
  logic [CHAN_W-1:0] red_r, red_nxt;
  logic [CHAN_W-1:0] grn_r, grn_nxt;
  logic [CHAN_W-1:0] blu_r, blu_nxt;

  always_comb begin
    case (sec5_r)
      SEC_RED_YEL: begin red_nxt = v5_r; grn_nxt = t5_r; blu_nxt = p5_r; end
      SEC_YEL_GRN: begin red_nxt = q5_r; grn_nxt = v5_r; blu_nxt = p5_r; end
      SEC_GRN_CYN: begin red_nxt = p5_r; grn_nxt = v5_r; blu_nxt = t5_r; end
      SEC_CYN_BLU: begin red_nxt = p5_r; grn_nxt = q5_r; blu_nxt = v5_r; end
      SEC_BLU_MAG: begin red_nxt = t5_r; grn_nxt = p5_r; blu_nxt = v5_r; end
      SEC_MAG_RED: begin red_nxt = v5_r; grn_nxt = p5_r; blu_nxt = q5_r; end
      default:     begin red_nxt = v5_r; grn_nxt = v5_r; blu_nxt = v5_r; end
    endcase
    if (s5_r == '0) begin
      red_nxt = v5_r;
      grn_nxt = v5_r;
      blu_nxt = v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      red_r <= red_nxt;
      grn_r <= grn_nxt;
      blu_r <= blu_nxt;
    end
  end

  assign out_tvalid = ctl.valid[NUM_STAGES-1];
  assign out_tdata  = {blu_r, grn_r, red_r};

`include "hsv_to_rgb_converter_assert.svh"

  `HSVRGB_CHECK(a_ready_chain, out_tready, in_tready)
  `HSVRGB_CHECK(a_gray_p, ctl.valid[2] && s3_r == '0, p3_r == v3_r)
  `HSVRGB_CHECK(a_q_bound, ctl.valid[4], q5_r <= v5_r && t5_r <= v5_r && p5_r <= v5_r)
  `HSVRGB_CHECK_NEXT(a_stall_hold, out_tvalid && !out_tready,
                     out_tvalid && out_tdata == $past(out_tdata))

endmodule
